// File: sv/sefc_pkg.sv
// Shared constants, codes and controller/datapath interface types of the frame checker.
package sefc_pkg;

    localparam int MAX_DATA_BYTES = 32;
    localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

    localparam int CFG_IDX_W = 8;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_START_BYTE = cfg_idx_t'(0);
    localparam cfg_idx_t REG_END_BYTE   = cfg_idx_t'(1);

    localparam logic [7:0] START_BYTE_RESET = 8'h02;
    localparam logic [7:0] END_BYTE_RESET   = 8'h03;
    localparam logic [7:0] MIN_FRAME        = 8'd5;
    localparam logic [7:0] POS_LIMIT        = 8'hFF;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_START    = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_BAD_END      = 3'd4,
        ST_BAD_SUM      = 3'd5
    } status_t;

    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } kind_t;

    // Result word, lowest bits last in the declaration
    typedef struct packed {
        logic [1:0] pad;
        logic [4:0] data_position;
        logic [7:0] data_value;
        logic [5:0] data_count;
        logic [7:0] command;
        status_t    status;
    } out_data_t;

    typedef struct packed {
        logic byte_accept;
        logic load_header;
        logic load_data;
        logic rd_en;
        logic idx_inc;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic frame_bad;
        logic count_zero;
        logic data_last;
    } dp_status_t;

endpackage

// File: sv/sefc_ctrl.sv
// Controller state machine: byte intake, frame evaluation and data result sequencing.
module sefc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    input  sefc_pkg::dp_status_t  sts,
    output sefc_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_RECV,
        S_EVAL,
        S_DATA
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_RECV: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.byte_accept = 1'b1;
                    if (s_tlast) begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (sts.out_free) begin
                    cmd.load_header = 1'b1;
                    if (sts.frame_bad || sts.count_zero) begin
                        cmd.clear  = 1'b1;
                        state_next = S_RECV;
                    end else begin
                        // fetch the first data byte
                        cmd.rd_en  = 1'b1;
                        state_next = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (sts.out_free) begin
                    cmd.load_data = 1'b1;
                    if (sts.data_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_RECV;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_RECV;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RECV;
        end else begin
            state_reg <= state_next;
        end
    end

    a_final_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.byte_accept && s_tlast) |=> (state_reg == S_EVAL))
        else $error("final byte did not start frame evaluation");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DATA) && !sts.out_free) |=> (state_reg == S_DATA))
        else $error("data sequence left while output stalled");

    a_no_intake_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_header || cmd.load_data) |-> !cmd.byte_accept)
        else $error("byte taken while results are being issued");

endmodule

// File: sv/sefc_datapath.sv
// Datapath: frame state registers, data byte store, status evaluation and result register.
module sefc_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  sefc_pkg::cfg_idx_t    cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [7:0]            rx_byte,
    input  sefc_pkg::ctrl_cmd_t   cmd,
    output sefc_pkg::dp_status_t  sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int IW = sefc_pkg::IDX_W;

    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;

    logic [7:0] byte_pos_reg;
    logic       too_long_reg;
    logic       start_ok_reg;
    logic [7:0] decl_len_reg;
    logic [7:0] sum_reg;
    logic [7:0] check_reg;
    logic [7:0] cmd_byte_reg;
    logic [7:0] last_rx_reg;

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [7:0]    rd_data_reg;
    logic [7:0]    mem [sefc_pkg::MAX_DATA_BYTES];

    logic                  out_valid_reg;
    sefc_pkg::out_data_t   out_data_reg;
    sefc_pkg::out_data_t   out_data_next;
    logic                  out_kind_reg;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic [8:0]    pay_end;
    logic [7:0]    data_off;
    logic          in_payload;
    logic          store_hit;
    logic [IW-1:0] wr_addr;
    sefc_pkg::status_t status;
    logic [7:0]    len_m1;
    logic [5:0]    count;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= sefc_pkg::START_BYTE_RESET;
            end_byte_reg   <= sefc_pkg::END_BYTE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == sefc_pkg::REG_START_BYTE) begin
                start_byte_reg <= cfg_data;
            end else if (cfg_index == sefc_pkg::REG_END_BYTE) begin
                end_byte_reg <= cfg_data;
            end
        end
    end

    // byte position decode
    always_comb begin
        pay_end    = 9'd2 + {1'b0, decl_len_reg};
        data_off   = byte_pos_reg - 8'd3;
        in_payload = (byte_pos_reg >= 8'd2) && ({1'b0, byte_pos_reg} < pay_end);
        store_hit  = cmd.byte_accept && !too_long_reg && (byte_pos_reg != sefc_pkg::POS_LIMIT)
                     && in_payload && (byte_pos_reg >= 8'd3)
                     && ({1'b0, data_off} < 9'(sefc_pkg::MAX_DATA_BYTES));
        wr_addr    = IW'(data_off);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            byte_pos_reg <= '0;
            too_long_reg <= 1'b0;
            start_ok_reg <= 1'b0;
            decl_len_reg <= '0;
            sum_reg      <= '0;
            check_reg    <= '0;
            cmd_byte_reg <= '0;
        end else if (cmd.byte_accept) begin
            if (too_long_reg || byte_pos_reg == sefc_pkg::POS_LIMIT) begin
                too_long_reg <= 1'b1;
            end else begin
                if (byte_pos_reg == 8'd0) begin
                    start_ok_reg <= (rx_byte == start_byte_reg);
                end else if (byte_pos_reg == 8'd1) begin
                    decl_len_reg <= rx_byte;
                end else if (in_payload) begin
                    sum_reg <= sum_reg + rx_byte;
                    if (byte_pos_reg == 8'd2) begin
                        cmd_byte_reg <= rx_byte;
                    end
                end else if ({1'b0, byte_pos_reg} == pay_end) begin
                    check_reg <= rx_byte;
                end
                byte_pos_reg <= byte_pos_reg + 8'd1;
            end
        end
    end

    // end byte is checked against the final byte, held here
    always_ff @(posedge aclk) begin
        if (cmd.byte_accept) begin
            last_rx_reg <= rx_byte;
        end
    end

    // status in check priority order
    always_comb begin
        if (!too_long_reg && byte_pos_reg < sefc_pkg::MIN_FRAME) begin
            status = sefc_pkg::ST_TOO_SHORT;
        end else if (!start_ok_reg) begin
            status = sefc_pkg::ST_BAD_START;
        end else if (too_long_reg || (decl_len_reg + 8'd4) != byte_pos_reg) begin
            status = sefc_pkg::ST_LEN_MISMATCH;
        end else if (last_rx_reg != end_byte_reg) begin
            status = sefc_pkg::ST_BAD_END;
        end else if (sum_reg != check_reg) begin
            status = sefc_pkg::ST_BAD_SUM;
        end else begin
            status = sefc_pkg::ST_OK;
        end
        len_m1 = decl_len_reg - 8'd1;
        if (len_m1 > 8'(sefc_pkg::MAX_DATA_BYTES)) begin
            count = 6'(sefc_pkg::MAX_DATA_BYTES);
        end else begin
            count = len_m1[5:0];
        end
    end

    always_comb begin
        if (cmd.clear) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IW'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_hit) begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_next];
        end
    end

    always_comb begin
        sts.out_free   = !out_valid_reg || m_tready;
        sts.frame_bad  = (status != sefc_pkg::ST_OK);
        sts.count_zero = (count == 6'd0);
        sts.data_last  = ((6'(idx_reg) + 6'd1) == count);
    end

    // result word
    always_comb begin
        out_data_next     = '0;
        out_data_next.status = status;
        out_last_next     = sts.frame_bad || sts.count_zero;
        if (status == sefc_pkg::ST_OK) begin
            out_data_next.command    = cmd_byte_reg;
            out_data_next.data_count = count;
        end
        if (cmd.load_data) begin
            out_data_next.status        = sefc_pkg::ST_OK;
            out_data_next.command       = cmd_byte_reg;
            out_data_next.data_count    = count;
            out_data_next.data_value    = rd_data_reg;
            out_data_next.data_position = 5'(idx_reg);
            out_last_next               = sts.data_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_header || cmd.load_data) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_header || cmd.load_data) begin
            out_data_reg <= out_data_next;
            out_kind_reg <= cmd.load_data ? sefc_pkg::KIND_DATA : sefc_pkg::KIND_HEADER;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (byte_pos_reg == 8'd0) && !too_long_reg)
        else $error("frame state not cleared");

    a_data_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_data |-> (6'(idx_reg) < count) && (status == sefc_pkg::ST_OK))
        else $error("data result outside the delivered range");

    a_too_long_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (too_long_reg && !cmd.clear) |=> too_long_reg)
        else $error("overlong flag dropped within a frame");

endmodule

// File: sv/stx_etx_frame_checker_core.sv
// Top level of the start/length/checksum/end frame checker.
//
//  channel   dir  handshake                 payload
//  s_        in   s_tvalid / s_tready       s_tdata rx_byte, s_tlast final_byte
//  m_        out  m_tvalid / m_tready       m_tdata result word, m_tuser kind, m_tlast run_end
//  cfg_      in   cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// One byte is taken per cycle while a frame streams in; non-final bytes give no result.
// The header is evaluated in the state that follows the final byte and registered, then up to
// MAX_DATA_BYTES data results follow at one per cycle unless m_tready stalls, each read from
// the store into a register ahead of its result. s_tready stays low from the final byte until
// the last result of the frame is loaded; a stall on m_tready holds the sequence and the input.
// Reset (aresetn low, synchronous) restores start 0x02 and end 0x03.
module stx_etx_frame_checker_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] status, [10:3] command, [16:11] data_count, [24:17] data_value,
    // [29:25] data_position, [31:30] zero
    output logic [31:0]           m_tdata,
    output logic                  m_tuser,   // [0] kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  sefc_pkg::cfg_idx_t    cfg_index,
    input  logic [7:0]            cfg_data
);

    sefc_pkg::ctrl_cmd_t  cmd;
    sefc_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    sefc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sefc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: tb/tb.sv
// Self-checking bench for the frame checker core against a built-in frame model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;
    // no register sits at this index; writes to it must be ignored
    localparam sefc_pkg::cfg_idx_t REG_UNUSED = sefc_pkg::cfg_idx_t'(8'hC7);

    typedef enum int {
        FLAW_NONE      = 0,
        FLAW_START     = 1,
        FLAW_END       = 2,
        FLAW_SUM       = 3,
        FLAW_LEN_SHORT = 4,
        FLAW_LEN_LONG  = 5,
        FLAW_NOISE     = 6
    } flaw_t;

    typedef struct {
        logic [7:0] rx;
        logic       fin;
    } rx_item_t;

    typedef struct {
        sefc_pkg::kind_t   kind;
        sefc_pkg::status_t status;
        logic [7:0]        command;
        logic [5:0]        count;
        logic [7:0]        value;
        logic [4:0]        position;
        logic              run_end;
    } frame_result_t;

    typedef logic [7:0] byte_q_t[$];

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    sefc_pkg::cfg_idx_t cfg_index = sefc_pkg::REG_START_BYTE;
    logic [7:0]  cfg_data  = 8'h00;

    rx_item_t      rx_items[$];
    frame_result_t frame_results[$];

    int tx_idle_pct    = 20;
    int rx_idle_pct    = 65;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;
    bit hold_taken     = 1'b0;

    // register copies, shared by the frame model and the frame generator
    logic [7:0] start_cfg = sefc_pkg::START_BYTE_RESET;
    logic [7:0] end_cfg   = sefc_pkg::END_BYTE_RESET;

    // frame model state
    logic [7:0] fr_pos      = 8'h00;
    logic       fr_too_long = 1'b0;
    logic       fr_start_ok = 1'b0;
    logic [7:0] fr_len      = 8'h00;
    logic [7:0] fr_sum      = 8'h00;
    logic [7:0] fr_check    = 8'h00;
    logic [7:0] fr_cmd      = 8'h00;
    logic [7:0] data_copy[sefc_pkg::MAX_DATA_BYTES];

    stx_etx_frame_checker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("tb: mismatch on %s at cycle %0d: got %0d, want %0d",
                 field, cycle_count, got, want);
        mismatch_count++;
    endtask

    function automatic void push_result(sefc_pkg::kind_t kind, sefc_pkg::status_t status,
                                        logic [7:0] command, logic [5:0] count,
                                        logic [7:0] value, logic [4:0] position,
                                        logic run_end);
        frame_result_t r;
        r.kind     = kind;
        r.status   = status;
        r.command  = command;
        r.count    = count;
        r.value    = value;
        r.position = position;
        r.run_end  = run_end;
        frame_results.push_back(r);
    endfunction

    // Advance the frame state by one byte; on the final byte queue the header and any data results.
    function automatic void predict_frame_byte(logic [7:0] rx, logic fin);
        int                pay_end;
        int                idx;
        int                cnt;
        logic [7:0]        wrapped_len;
        sefc_pkg::status_t st;
        if (fr_too_long || fr_pos == sefc_pkg::POS_LIMIT) begin
            fr_too_long = 1'b1;
        end else begin
            pay_end = 2 + int'(fr_len);
            if (fr_pos == 8'd0) begin
                fr_start_ok = (rx == start_cfg);
            end else if (fr_pos == 8'd1) begin
                fr_len = rx;
            end else if (int'(fr_pos) < pay_end) begin
                fr_sum = fr_sum + rx;
                if (fr_pos == 8'd2) begin
                    fr_cmd = rx;
                end else begin
                    idx = int'(fr_pos) - 3;
                    if (idx < sefc_pkg::MAX_DATA_BYTES) data_copy[idx] = rx;
                end
            end else if (int'(fr_pos) == pay_end) begin
                fr_check = rx;
            end
            fr_pos = fr_pos + 8'd1;
        end
        if (!fin) return;

        wrapped_len = fr_len + 8'd4;
        if (!fr_too_long && fr_pos < sefc_pkg::MIN_FRAME) st = sefc_pkg::ST_TOO_SHORT;
        else if (!fr_start_ok)                  st = sefc_pkg::ST_BAD_START;
        else if (fr_too_long || wrapped_len != fr_pos) st = sefc_pkg::ST_LEN_MISMATCH;
        else if (rx != end_cfg)                 st = sefc_pkg::ST_BAD_END;
        else if (fr_sum != fr_check)            st = sefc_pkg::ST_BAD_SUM;
        else                                    st = sefc_pkg::ST_OK;

        if (st != sefc_pkg::ST_OK) begin
            push_result(sefc_pkg::KIND_HEADER, st, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1);
        end else begin
            cnt = int'(fr_len) - 1;
            if (cnt > sefc_pkg::MAX_DATA_BYTES) cnt = sefc_pkg::MAX_DATA_BYTES;
            push_result(sefc_pkg::KIND_HEADER, sefc_pkg::ST_OK, fr_cmd, 6'(cnt),
                        8'h00, 5'd0, cnt == 0);
            for (int k = 0; k < cnt; k++)
                push_result(sefc_pkg::KIND_DATA, sefc_pkg::ST_OK, fr_cmd, 6'(cnt),
                            data_copy[k], 5'(k), k + 1 == cnt);
        end
        fr_pos      = 8'h00;
        fr_too_long = 1'b0;
        fr_start_ok = 1'b0;
        fr_len      = 8'h00;
        fr_sum      = 8'h00;
        fr_check    = 8'h00;
        fr_cmd      = 8'h00;
    endfunction

    // byte source: hold the current transfer until taken, then offer the next or idle
    always @(posedge aclk) begin : byte_driver
        rx_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (rx_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                item = rx_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.rx;
                s_tlast  <= item.fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : hold_counter
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : result_sink
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        sefc_pkg::out_data_t word;
        frame_result_t       want;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_frame_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                word = sefc_pkg::out_data_t'(m_tdata);
                if (frame_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = frame_results.pop_front();
                    if (sefc_pkg::kind_t'(m_tuser) != want.kind)
                        report_mismatch("kind", m_tuser, want.kind);
                    if (word.status != want.status)
                        report_mismatch("status", word.status, want.status);
                    if (word.command != want.command)
                        report_mismatch("command", word.command, want.command);
                    if (word.data_count != want.count)
                        report_mismatch("data_count", word.data_count, want.count);
                    if (word.data_value != want.value)
                        report_mismatch("data_value", word.data_value, want.value);
                    if (word.data_position != want.position)
                        report_mismatch("data_position", word.data_position, want.position);
                    if (m_tlast != want.run_end)
                        report_mismatch("run_end", m_tlast, want.run_end);
                end
            end
        end
    end

    function automatic int push_buffer(byte_q_t b);
        rx_item_t item;
        foreach (b[i]) begin
            item.rx  = b[i];
            item.fin = (i == b.size() - 1);
            rx_items.push_back(item);
        end
        return b.size();
    endfunction

    function automatic byte_q_t build_frame(int len, flaw_t flaw);
        byte_q_t    b;
        logic [7:0] sum;
        logic [7:0] v;
        int         n;
        sum = 8'h00;
        b.push_back(start_cfg);
        b.push_back(8'(len));
        for (int i = 0; i < len; i++) begin
            v = 8'($urandom);
            b.push_back(v);
            sum = sum + v;
        end
        b.push_back(sum);
        b.push_back(end_cfg);
        case (flaw)
            FLAW_START: b[0] = b[0] ^ 8'($urandom_range(1, 255));
            FLAW_END:   b[b.size() - 1] = b[b.size() - 1] ^ 8'($urandom_range(1, 255));
            FLAW_SUM:   b[len + 2] = b[len + 2] ^ 8'($urandom_range(1, 255));
            FLAW_LEN_SHORT: b.delete($urandom_range(2, b.size() - 2));
            FLAW_LEN_LONG:  b.insert($urandom_range(2, b.size() - 1), 8'($urandom));
            FLAW_NOISE: begin
                b.delete();
                n = $urandom_range(1, 12);
                repeat (n) b.push_back(8'($urandom));
            end
            default: ;
        endcase
        return b;
    endfunction

    // mostly well-formed frames with random content, some long enough to hit the data clamp
    function automatic void queue_random(int budget);
        int    added;
        int    len;
        flaw_t flaw;
        added = 0;
        while (added < budget) begin
            len  = ($urandom_range(99) < 10) ? $urandom_range(33, 40) : $urandom_range(0, 12);
            flaw = ($urandom_range(99) < 70) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
            added += push_buffer(build_frame(len, flaw));
        end
    endfunction

    task automatic write_reg(sefc_pkg::cfg_idx_t idx, logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sefc_pkg::REG_START_BYTE: start_cfg = val;
            sefc_pkg::REG_END_BYTE:   end_cfg   = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (rx_items.size() != 0 || s_tvalid || frame_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        byte_q_t b;
        int      dummy;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames under the reset register values
        @(negedge aclk);
        b.delete();
        b.push_back(8'h02);
        dummy = push_buffer(b);
        dummy = push_buffer(build_frame(0, FLAW_NONE));
        dummy = push_buffer(build_frame(1, FLAW_NONE));
        dummy = push_buffer(build_frame(1, FLAW_START));
        // declared length that wraps below the minimum frame size
        b.delete();
        b.push_back(8'h02);
        b.push_back(8'hFC);
        b.push_back(8'hFF);
        b.push_back(8'h00);
        b.push_back(8'h03);
        dummy = push_buffer(b);
        dummy = push_buffer(build_frame(1, FLAW_END));
        dummy = push_buffer(build_frame(2, FLAW_SUM));
        b = build_frame(3, FLAW_NONE);
        b[3] = 8'h00;
        b[4] = 8'hFF;
        b[5] = b[2] + 8'hFF;
        dummy = push_buffer(b);
        wait_drained();

        write_reg(sefc_pkg::REG_START_BYTE, 8'h00);
        write_reg(sefc_pkg::REG_END_BYTE, 8'hFF);
        @(negedge aclk);
        tx_idle_pct = 20;
        rx_idle_pct = 65;
        queue_random(8);
        wait_drained();

        write_reg(sefc_pkg::REG_START_BYTE, 8'hFF);
        write_reg(sefc_pkg::REG_END_BYTE, 8'h00);
        @(negedge aclk);
        tx_idle_pct = 65;
        rx_idle_pct = 20;
        queue_random(8);
        wait_drained();

        write_reg(REG_UNUSED, 8'($urandom));
        write_reg(sefc_pkg::REG_START_BYTE, 8'($urandom));
        write_reg(sefc_pkg::REG_END_BYTE, 8'($urandom));
        @(negedge aclk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        // two short good frames back to back fill the result side during the hold
        dummy = push_buffer(build_frame(1, FLAW_NONE));
        dummy = push_buffer(build_frame(1, FLAW_NONE));
        queue_random(8);
        // one byte past the position counter's range
        b = build_frame(8, FLAW_NONE);
        while (b.size() < 256) b.insert(b.size() - 1, 8'($urandom));
        dummy = push_buffer(b);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/sefc_pkg.sv
sv/sefc_ctrl.sv
sv/sefc_datapath.sv
sv/stx_etx_frame_checker_core.sv
tb/tb.sv
